// ===== hdl/rnpe_pkg.sv =====
// shared types, codes and constants of the radio node pairing engine
`timescale 1ns / 1ps

package rnpe_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 24;

  // reset values of the configuration registers
  localparam logic [TimeW-1:0] PairIntervalRst  = 32'd5000;
  localparam logic [TimeW-1:0] BeatIntervalRst  = 32'd60000;
  localparam logic [TimeW-1:0] ReportIntervalRst = 32'd60000;
  localparam logic [ByteW-1:0] MaxAttemptsRst   = 8'd20;
  localparam logic [AddrW-1:0] NodeAddressRst   = 48'd0;
  localparam logic [ByteW-1:0] MinFrameLenRst   = 8'd11;
  localparam logic [ByteW-1:0] MinPairLenRst    = 8'd12;
  localparam logic [ByteW-1:0] MinCmdLenRst     = 8'd12;

  // command code that asks for a restart
  localparam logic [ByteW-1:0] RestartCode = 8'hFF;

  // result buffer depth
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_FRAME  = 2'd2,
    FUNC_REPAIR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MSG_PAIR_REPLY = 2'd0,
    MSG_COMMAND    = 2'd1,
    MSG_OTHER      = 2'd2,
    MSG_OTHER_ALT  = 2'd3
  } msg_kind_e;

  typedef enum logic [2:0] {
    EV_PAIR_REQ = 3'd0,
    EV_BEAT     = 3'd1,
    EV_DATA     = 3'd2,
    EV_PAIRED   = 3'd3,
    EV_COMMAND  = 3'd4,
    EV_RESTART  = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAIR_INTERVAL   = 3'd0,
    CFG_BEAT_INTERVAL   = 3'd1,
    CFG_REPORT_INTERVAL = 3'd2,
    CFG_MAX_ATTEMPTS    = 3'd3,
    CFG_NODE_ADDRESS    = 3'd4,
    CFG_MIN_FRAME_LEN   = 3'd5,
    CFG_MIN_PAIR_LEN    = 3'd6,
    CFG_MIN_CMD_LEN     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] pair_interval;
    logic [TimeW-1:0] heartbeat_interval;
    logic [TimeW-1:0] report_interval;
    logic [ByteW-1:0] max_attempts;
    logic [AddrW-1:0] node_address;
    logic [ByteW-1:0] min_frame_len;
    logic [ByteW-1:0] min_pair_reply_len;
    logic [ByteW-1:0] min_command_len;
  } cfg_t;

  typedef struct packed {
    func_e            func;
    logic [TimeW-1:0] now_ms;
    logic [ByteW-1:0] frame_len;
    logic [1:0]       msg_kind;
    logic [AddrW-1:0] frame_address;
    logic [ByteW-1:0] slot_in;
    logic [ByteW-1:0] command_in;
  } item_t;

  typedef struct packed {
    event_e           event_kind;
    logic [ByteW-1:0] seq_out;
    logic [ByteW-1:0] slot_out;
    logic [ByteW-1:0] command_out;
    logic             last;
  } res_t;

  // results of one item, entry 0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t [1:0] ent;
  } push_t;

endpackage

// ===== hdl/rnpe_cfg_regs.sv =====
// configuration register bank of the pairing engine
`timescale 1ns / 1ps

module rnpe_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rnpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rnpe_pkg::CfgDataW-1:0] cfg_data_i,
  output rnpe_pkg::cfg_t                cfg_o
);
  import rnpe_pkg::*;

  cfg_t cfg_q;

  // register writes, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_interval      <= PairIntervalRst;
      cfg_q.heartbeat_interval <= BeatIntervalRst;
      cfg_q.report_interval    <= ReportIntervalRst;
      cfg_q.max_attempts       <= MaxAttemptsRst;
      cfg_q.node_address       <= NodeAddressRst;
      cfg_q.min_frame_len      <= MinFrameLenRst;
      cfg_q.min_pair_reply_len <= MinPairLenRst;
      cfg_q.min_command_len    <= MinCmdLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PAIR_INTERVAL:   cfg_q.pair_interval      <= cfg_data_i[TimeW-1:0];
        CFG_BEAT_INTERVAL:   cfg_q.heartbeat_interval <= cfg_data_i[TimeW-1:0];
        CFG_REPORT_INTERVAL: cfg_q.report_interval    <= cfg_data_i[TimeW-1:0];
        CFG_MAX_ATTEMPTS:    cfg_q.max_attempts       <= cfg_data_i[ByteW-1:0];
        CFG_NODE_ADDRESS:    cfg_q.node_address       <= cfg_data_i[AddrW-1:0];
        CFG_MIN_FRAME_LEN:   cfg_q.min_frame_len      <= cfg_data_i[ByteW-1:0];
        CFG_MIN_PAIR_LEN:    cfg_q.min_pair_reply_len <= cfg_data_i[ByteW-1:0];
        CFG_MIN_CMD_LEN:     cfg_q.min_command_len    <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/rnpe_core.sv =====
// link state and per-item decision logic of the pairing engine
`timescale 1ns / 1ps

module rnpe_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  rnpe_pkg::item_t item_i,
  input  rnpe_pkg::cfg_t  cfg_i,
  output rnpe_pkg::push_t push_o
);
  import rnpe_pkg::*;

  logic             paired_q, paired_d;
  logic [ByteW-1:0] slot_q, slot_d;
  logic [ByteW-1:0] seq_q, seq_d;
  logic [TimeW-1:0] pair_time_q, pair_time_d;
  logic [TimeW-1:0] beat_time_q, beat_time_d;
  logic [TimeW-1:0] report_time_q, report_time_d;
  logic [ByteW-1:0] attempt_q, attempt_d;

  logic [TimeW-1:0] pair_age, beat_age, report_age;
  logic             pair_due, beat_due, report_due;
  logic             mine, len_ok;
  push_t            push;

  // elapsed times, wrapping
  assign pair_age   = item_i.now_ms - pair_time_q;
  assign beat_age   = item_i.now_ms - beat_time_q;
  assign report_age = item_i.now_ms - report_time_q;
  assign pair_due   = (pair_age >= cfg_i.pair_interval) &&
                      (attempt_q < cfg_i.max_attempts);
  assign beat_due   = beat_age >= cfg_i.heartbeat_interval;
  assign report_due = report_age >= cfg_i.report_interval;

  // frame filter
  assign mine   = item_i.frame_address == cfg_i.node_address;
  assign len_ok = mine && (item_i.frame_len >= cfg_i.min_frame_len);

  // decision and next state
  always_comb begin
    paired_d      = paired_q;
    slot_d        = slot_q;
    seq_d         = seq_q;
    pair_time_d   = pair_time_q;
    beat_time_d   = beat_time_q;
    report_time_d = report_time_q;
    attempt_d     = attempt_q;
    push          = '0;

    case (item_i.func)
      FUNC_START: begin
        paired_d      = 1'b0;
        attempt_d     = '0;
        pair_time_d   = '0;
        beat_time_d   = '0;
        report_time_d = '0;
        seq_d         = 8'd1;
        push.cnt                = 2'd1;
        push.ent[0].event_kind  = EV_PAIR_REQ;
      end
      FUNC_TICK: begin
        if (!paired_q) begin
          if (pair_due) begin
            pair_time_d = item_i.now_ms;
            attempt_d   = attempt_q + 8'd1;
            seq_d       = seq_q + 8'd1;
            push.cnt               = 2'd1;
            push.ent[0].event_kind = EV_PAIR_REQ;
            push.ent[0].seq_out    = seq_q;
          end
        end else begin
          if (beat_due) begin
            beat_time_d = item_i.now_ms;
          end
          if (report_due) begin
            report_time_d = item_i.now_ms;
          end
          seq_d = seq_q + {7'd0, beat_due} + {7'd0, report_due};
          if (beat_due) begin
            push.ent[0].event_kind = EV_BEAT;
            push.ent[0].seq_out    = seq_q;
            push.ent[1].event_kind = EV_DATA;
            push.ent[1].seq_out    = seq_q + 8'd1;
            push.cnt               = report_due ? 2'd2 : 2'd1;
          end else if (report_due) begin
            push.ent[0].event_kind = EV_DATA;
            push.ent[0].seq_out    = seq_q;
            push.cnt               = 2'd1;
          end
        end
      end
      FUNC_FRAME: begin
        if (len_ok && (item_i.msg_kind == MSG_PAIR_REPLY) &&
            (item_i.frame_len >= cfg_i.min_pair_reply_len)) begin
          paired_d      = 1'b1;
          slot_d        = item_i.slot_in;
          attempt_d     = '0;
          report_time_d = item_i.now_ms;
          seq_d         = seq_q + 8'd1;
          push.cnt               = 2'd2;
          push.ent[0].event_kind = EV_PAIRED;
          push.ent[0].slot_out   = item_i.slot_in;
          push.ent[1].event_kind = EV_DATA;
          push.ent[1].seq_out    = seq_q;
        end else if (len_ok && (item_i.msg_kind == MSG_COMMAND) &&
                     (item_i.frame_len >= cfg_i.min_command_len)) begin
          push.cnt = 2'd1;
          if (item_i.command_in == RestartCode) begin
            push.ent[0].event_kind = EV_RESTART;
          end else begin
            push.ent[0].event_kind  = EV_COMMAND;
            push.ent[0].command_out = item_i.command_in;
          end
        end
      end
      default: begin
        paired_d    = 1'b0;
        attempt_d   = '0;
        pair_time_d = '0;
      end
    endcase

    // mark the final result of this item
    if (push.cnt == 2'd2) begin
      push.ent[1].last = 1'b1;
    end else if (push.cnt == 2'd1) begin
      push.ent[0].last = 1'b1;
    end

    if (!go_i) begin
      push.cnt = 2'd0;
    end
  end

  // link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paired_q      <= 1'b0;
      slot_q        <= '0;
      seq_q         <= '0;
      pair_time_q   <= '0;
      beat_time_q   <= '0;
      report_time_q <= '0;
      attempt_q     <= '0;
    end else if (go_i) begin
      paired_q      <= paired_d;
      slot_q        <= slot_d;
      seq_q         <= seq_d;
      pair_time_q   <= pair_time_d;
      beat_time_q   <= beat_time_d;
      report_time_q <= report_time_d;
      attempt_q     <= attempt_d;
    end
  end

  assign push_o = push;

endmodule

// ===== hdl/rnpe_res_fifo.sv =====
// result buffer: takes up to two words per cycle, gives one per cycle while the receiver is ready
`timescale 1ns / 1ps

module rnpe_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rnpe_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output rnpe_pkg::res_t  res_o
);
  import rnpe_pkg::*;

  res_t               buf_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] count_q;
  logic               pop;
  logic [ResPtrW-1:0] wr_ptr_nxt;

  assign pop        = valid_o && ready_i;
  assign wr_ptr_nxt = wr_ptr_q + 2'd1;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      buf_q[wr_ptr_q] <= push_i.ent[0];
    end
    if (push_i.cnt == 2'd2) begin
      buf_q[wr_ptr_nxt] <= push_i.ent[1];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.cnt;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, push_i.cnt} - {2'b0, pop};
    end
  end

  assign room_o  = count_q <= ResCntW'(ResDepth - 2);
  assign valid_o = count_q != '0;
  assign res_o   = buf_q[rd_ptr_q];

endmodule

// ===== hdl/radio_node_pairing_engine.sv =====
// Sensor-node pairing engine, top level.
// Flow: an accepted word is registered in the input register, decided by the core once
// the result buffer has room, and its result words are registered in that buffer and offered.
// Throughput: one input word per cycle while results drain and the buffer has room; the output
// side gives one result word per cycle while the receiver is ready, so two results go as two words.
// Reset: asynchronous, active low; link state, buffer and registers to reset values.
`timescale 1ns / 1ps

module radio_node_pairing_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // now_ms[31:0], frame_len[39:32], msg_kind[41:40], frame_address[89:42],
  // slot_in[97:90], command_in[105:98], zero fill
  input  logic [rnpe_pkg::InDataW-1:0]   s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // seq_out[7:0], slot_out[15:8], command_out[23:16]
  output logic [rnpe_pkg::OutDataW-1:0]  m_axis_tdata,
  // event_kind[2:0]
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [rnpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rnpe_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rnpe_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid_q;
  logic  room, go, in_acc;
  push_t push;
  res_t  res;

  rnpe_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register, refilled in the cycle it is consumed
  assign go            = item_valid_q && room;
  assign s_axis_tready = !item_valid_q || go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.func          <= func_e'(s_axis_tuser);
      item_q.now_ms        <= s_axis_tdata[31:0];
      item_q.frame_len     <= s_axis_tdata[39:32];
      item_q.msg_kind      <= s_axis_tdata[41:40];
      item_q.frame_address <= s_axis_tdata[89:42];
      item_q.slot_in       <= s_axis_tdata[97:90];
      item_q.command_in    <= s_axis_tdata[105:98];
    end
  end

  rnpe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item_q),
    .cfg_i  (cfg),
    .push_o (push)
  );

  rnpe_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // result word packing
  assign m_axis_tdata = {res.command_out, res.slot_out, res.seq_out};
  assign m_axis_tuser = res.event_kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== tb/sv/radio_node_pairing_engine_checker.sv =====
// link event predictor and result word checker for the pairing engine bench
`timescale 1ns / 1ps

module radio_node_pairing_engine_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // now_ms, frame_len, msg_kind, frame_address, slot_in, command_in, zero fill
  input  logic [rnpe_pkg::InDataW-1:0]  s_axis_tdata,
  // func
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // seq_out, slot_out, command_out
  input  logic [rnpe_pkg::OutDataW-1:0] m_axis_tdata,
  // event_kind
  input  logic [2:0]                    m_axis_tuser,
  input  logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [rnpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rnpe_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            err_cnt_o,
  output int                            pending_o,
  output int                            words_checked_o
);

  import rnpe_pkg::*;

  // predicted link state and register copy
  cfg_t             link_cfg;
  logic             linked;
  logic [ByteW-1:0] seq_r;
  logic [ByteW-1:0] tries;
  logic [TimeW-1:0] last_req_ms;
  logic [TimeW-1:0] last_beat_ms;
  logic [TimeW-1:0] last_report_ms;

  // result words still owed by the block, oldest first
  res_t event_q[$];

  // queue a sent frame and bump the sequence number
  task automatic queue_send(input event_e kind);
    res_t word;
    word = '0;
    word.event_kind = kind;
    word.seq_out = seq_r;
    event_q.push_back(word);
    seq_r = seq_r + 8'd1;
  endtask

  // work out the events that one accepted word causes
  task automatic predict_link(input item_t it);
    res_t             word;
    int               base;
    logic [TimeW-1:0] since_req;
    logic [TimeW-1:0] since_beat;
    logic [TimeW-1:0] since_report;
    base = event_q.size();
    since_req = it.now_ms - last_req_ms;
    since_beat = it.now_ms - last_beat_ms;
    since_report = it.now_ms - last_report_ms;
    case (it.func)
      FUNC_START: begin
        linked = 1'b0;
        tries = '0;
        last_req_ms = '0;
        last_beat_ms = '0;
        last_report_ms = '0;
        seq_r = '0;
        queue_send(EV_PAIR_REQ);
      end
      FUNC_TICK: begin
        if (!linked) begin
          if (since_req >= link_cfg.pair_interval && tries < link_cfg.max_attempts) begin
            last_req_ms = it.now_ms;
            tries = tries + 8'd1;
            queue_send(EV_PAIR_REQ);
          end
        end else begin
          // heartbeat goes out ahead of sensor data
          if (since_beat >= link_cfg.heartbeat_interval) begin
            last_beat_ms = it.now_ms;
            queue_send(EV_BEAT);
          end
          if (since_report >= link_cfg.report_interval) begin
            last_report_ms = it.now_ms;
            queue_send(EV_DATA);
          end
        end
      end
      FUNC_FRAME: begin
        if (it.frame_address == link_cfg.node_address &&
            it.frame_len >= link_cfg.min_frame_len) begin
          if (it.msg_kind == MSG_PAIR_REPLY && it.frame_len >= link_cfg.min_pair_reply_len) begin
            linked = 1'b1;
            tries = '0;
            word = '0;
            word.event_kind = EV_PAIRED;
            word.slot_out = it.slot_in;
            event_q.push_back(word);
            queue_send(EV_DATA);
            last_report_ms = it.now_ms;
          end else if (it.msg_kind == MSG_COMMAND &&
                       it.frame_len >= link_cfg.min_command_len) begin
            word = '0;
            if (it.command_in == RestartCode) begin
              word.event_kind = EV_RESTART;
            end else begin
              word.event_kind = EV_COMMAND;
              word.command_out = it.command_in;
            end
            event_q.push_back(word);
          end
        end
      end
      default: begin
        linked = 1'b0;
        tries = '0;
        last_req_ms = '0;
      end
    endcase
    // mark the final event of this word
    if (event_q.size() > base) begin
      word = event_q.pop_back();
      word.last = 1'b1;
      event_q.push_back(word);
    end
  endtask

  // compare one result word against the oldest owed event
  task automatic check_word();
    res_t want;
    words_checked_o++;
    if (event_q.size() == 0) begin
      err_cnt_o++;
      if (err_cnt_o <= 10)
        $display("unexpected result word: kind %0d seq %0d slot %0d cmd %0d last %0b",
                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                 m_axis_tlast);
    end else begin
      want = event_q.pop_front();
      if (3'(want.event_kind) !== m_axis_tuser || want.seq_out !== m_axis_tdata[7:0] ||
          want.slot_out !== m_axis_tdata[15:8] || want.command_out !== m_axis_tdata[23:16] ||
          want.last !== m_axis_tlast) begin
        err_cnt_o++;
        if (err_cnt_o <= 10)
          $display("result mismatch: expected kind %0d seq %0d slot %0d cmd %0d last %0b, got kind %0d seq %0d slot %0d cmd %0d last %0b",
                   3'(want.event_kind), want.seq_out, want.slot_out, want.command_out,
                   want.last, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                   m_axis_tdata[23:16], m_axis_tlast);
      end
    end
  endtask

  // watch register writes and both streams
  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t seen;
    if (!rst_ni) begin
      link_cfg.pair_interval = PairIntervalRst;
      link_cfg.heartbeat_interval = BeatIntervalRst;
      link_cfg.report_interval = ReportIntervalRst;
      link_cfg.max_attempts = MaxAttemptsRst;
      link_cfg.node_address = NodeAddressRst;
      link_cfg.min_frame_len = MinFrameLenRst;
      link_cfg.min_pair_reply_len = MinPairLenRst;
      link_cfg.min_command_len = MinCmdLenRst;
      linked = 1'b0;
      seq_r = '0;
      tries = '0;
      last_req_ms = '0;
      last_beat_ms = '0;
      last_report_ms = '0;
      event_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
      words_checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PAIR_INTERVAL:   link_cfg.pair_interval = cfg_data_i[TimeW-1:0];
          CFG_BEAT_INTERVAL:   link_cfg.heartbeat_interval = cfg_data_i[TimeW-1:0];
          CFG_REPORT_INTERVAL: link_cfg.report_interval = cfg_data_i[TimeW-1:0];
          CFG_MAX_ATTEMPTS:    link_cfg.max_attempts = cfg_data_i[ByteW-1:0];
          CFG_NODE_ADDRESS:    link_cfg.node_address = cfg_data_i[AddrW-1:0];
          CFG_MIN_FRAME_LEN:   link_cfg.min_frame_len = cfg_data_i[ByteW-1:0];
          CFG_MIN_PAIR_LEN:    link_cfg.min_pair_reply_len = cfg_data_i[ByteW-1:0];
          default:             link_cfg.min_command_len = cfg_data_i[ByteW-1:0];
        endcase
      end
      if (m_axis_tvalid && m_axis_tready)
        check_word();
      if (s_axis_tvalid && s_axis_tready) begin
        seen.func = func_e'(s_axis_tuser);
        seen.now_ms = s_axis_tdata[31:0];
        seen.frame_len = s_axis_tdata[39:32];
        seen.msg_kind = s_axis_tdata[41:40];
        seen.frame_address = s_axis_tdata[89:42];
        seen.slot_in = s_axis_tdata[97:90];
        seen.command_in = s_axis_tdata[105:98];
        predict_link(seen);
      end
      pending_o = event_q.size();
    end
  end

endmodule

// ===== tb/sv/radio_node_pairing_engine_tb.sv =====
// stimulus, stall control and verdict for the pairing engine bench
`timescale 1ns / 1ps

module radio_node_pairing_engine_tb;

  import rnpe_pkg::*;

  // cycles with no word moving on either side before the run is abandoned
  localparam int QuietLimit = 5000;
  // receiver hold-off used to back up the result buffer
  localparam int SqueezeCycles = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int err_cnt;
  int pending;
  int words_checked;

  // stimulus bookkeeping
  cfg_t             link_cfg;
  logic [TimeW-1:0] clock_ms = '0;
  int               words_sent = 0;
  int               settings_used = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               squeeze_req = 0;
  int               squeeze_seen = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;

  radio_node_pairing_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  radio_node_pairing_engine_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: random stalls plus the occasional long hold-off
  always @(posedge clk_i) begin
    if (squeeze_req != squeeze_seen) begin
      squeeze_seen = squeeze_req;
      hold_left = SqueezeCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles where nothing is accepted
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no word accepted for %0d cycles, %0d results owed",
               QuietLimit, pending);
      $display("radio_node_pairing_engine regression: fail");
      $finish;
    end
  end

  function automatic item_t mk_item(input func_e f, input logic [TimeW-1:0] now,
                                    input logic [ByteW-1:0] len, input msg_kind_e kind,
                                    input logic [AddrW-1:0] addr,
                                    input logic [ByteW-1:0] slot,
                                    input logic [ByteW-1:0] cmd);
    item_t it;
    it.func = f;
    it.now_ms = now;
    it.frame_len = len;
    it.msg_kind = kind;
    it.frame_address = addr;
    it.slot_in = slot;
    it.command_in = cmd;
    return it;
  endfunction

  function automatic cfg_t mk_cfg(input logic [TimeW-1:0] pair_iv,
                                  input logic [TimeW-1:0] beat_iv,
                                  input logic [TimeW-1:0] report_iv,
                                  input logic [ByteW-1:0] attempts,
                                  input logic [AddrW-1:0] addr,
                                  input logic [ByteW-1:0] frame_min,
                                  input logic [ByteW-1:0] pair_min,
                                  input logic [ByteW-1:0] cmd_min);
    cfg_t c;
    c.pair_interval = pair_iv;
    c.heartbeat_interval = beat_iv;
    c.report_interval = report_iv;
    c.max_attempts = attempts;
    c.node_address = addr;
    c.min_frame_len = frame_min;
    c.min_pair_reply_len = pair_min;
    c.min_command_len = cmd_min;
    return c;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[AddrW-1:0];
  endfunction

  // offer one input word and hold it until accepted
  task automatic send_word(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {6'b0, it.command_in, it.slot_in, it.frame_address, it.msg_kind,
                     it.frame_len, it.now_ms};
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    words_sent++;
  endtask

  // stop offering, let owed results drain and the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // write every register once the block is idle
  task automatic program_link(input cfg_t c);
    cfg_idx_e ri;
    settle();
    link_cfg = c;
    settings_used++;
    ri = ri.first();
    repeat (ri.num()) begin
      case (ri)
        CFG_PAIR_INTERVAL:   cfg_data_i <= CfgDataW'(c.pair_interval);
        CFG_BEAT_INTERVAL:   cfg_data_i <= CfgDataW'(c.heartbeat_interval);
        CFG_REPORT_INTERVAL: cfg_data_i <= CfgDataW'(c.report_interval);
        CFG_MAX_ATTEMPTS:    cfg_data_i <= CfgDataW'(c.max_attempts);
        CFG_NODE_ADDRESS:    cfg_data_i <= CfgDataW'(c.node_address);
        CFG_MIN_FRAME_LEN:   cfg_data_i <= CfgDataW'(c.min_frame_len);
        CFG_MIN_PAIR_LEN:    cfg_data_i <= CfgDataW'(c.min_pair_reply_len);
        default:             cfg_data_i <= CfgDataW'(c.min_command_len);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= ri;
      @(posedge clk_i);
      ri = ri.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // one register setting followed by random traffic; span 0 means scattered times
  task automatic run_phase(input cfg_t c, input int n, input int span, input int s_idle,
                           input int r_idle, input bit squeeze);
    item_t            it;
    int               pick;
    logic [ByteW-1:0] need;
    program_link(c);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (squeeze)
      squeeze_req++;
    for (int k = 0; k < n; k++) begin
      // noise in every field, then shaped by function
      it.frame_len = 8'($urandom_range(255));
      it.msg_kind = 2'($urandom_range(3));
      it.frame_address = rand_addr();
      it.slot_in = 8'($urandom_range(255));
      it.command_in = 8'($urandom_range(255));
      if (span == 0 || $urandom_range(9) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + TimeW'($urandom_range(span));
      it.now_ms = clock_ms;
      pick = $urandom_range(99);
      if (pick < 3) begin
        it.func = FUNC_START;
      end else if (pick < 7) begin
        it.func = FUNC_REPAIR;
      end else if (pick < 35) begin
        it.func = FUNC_FRAME;
        pick = $urandom_range(99);
        if (pick < 45)
          it.msg_kind = MSG_PAIR_REPLY;
        else if (pick < 85)
          it.msg_kind = MSG_COMMAND;
        else
          it.msg_kind = $urandom_range(1) ? MSG_OTHER : MSG_OTHER_ALT;
        // mostly frames aimed at this node, some near misses
        pick = $urandom_range(99);
        if (pick < 80)
          it.frame_address = link_cfg.node_address;
        else if (pick >= 90)
          it.frame_address = link_cfg.node_address ^ (48'd1 << $urandom_range(AddrW - 1));
        need = link_cfg.min_frame_len;
        if (it.msg_kind == MSG_PAIR_REPLY && link_cfg.min_pair_reply_len > need)
          need = link_cfg.min_pair_reply_len;
        if (it.msg_kind == MSG_COMMAND && link_cfg.min_command_len > need)
          need = link_cfg.min_command_len;
        if ($urandom_range(3) != 0)
          it.frame_len = 8'($urandom_range(255, need));
        if ($urandom_range(3) == 0)
          it.command_in = RestartCode;
      end else begin
        it.func = FUNC_TICK;
      end
      send_word(it);
    end
  endtask

  initial begin
    link_cfg = mk_cfg(PairIntervalRst, BeatIntervalRst, ReportIntervalRst, MaxAttemptsRst,
                      NodeAddressRst, MinFrameLenRst, MinPairLenRst, MinCmdLenRst);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset register values, node address zero
    send_idle_pct = 19;
    recv_idle_pct = 57;
    send_word(mk_item(FUNC_TICK, 32'd0, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd5000, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_START, 32'd100, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd4999, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd5000, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    // short header, short pairing reply, wrong address
    send_word(mk_item(FUNC_FRAME, 32'd6000, 8'd10, MSG_PAIR_REPLY, 48'd0, 8'd3, 8'd0));
    send_word(mk_item(FUNC_FRAME, 32'd6000, 8'd11, MSG_PAIR_REPLY, 48'd0, 8'd3, 8'd0));
    send_word(mk_item(FUNC_FRAME, 32'd6000, 8'd12, MSG_PAIR_REPLY, 48'd1, 8'd3, 8'd0));
    send_word(mk_item(FUNC_FRAME, 32'd7000, 8'hFF, MSG_PAIR_REPLY, 48'd0, 8'hFF, 8'd0));
    // heartbeat alone, then both frames across the top of the time range
    send_word(mk_item(FUNC_TICK, 32'd60000, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd2, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    // commands: plain, restart, too short, other kinds
    send_word(mk_item(FUNC_FRAME, 32'd3, 8'd12, MSG_COMMAND, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_FRAME, 32'd4, 8'hFF, MSG_COMMAND, 48'd0, 8'd0, RestartCode));
    send_word(mk_item(FUNC_FRAME, 32'd5, 8'd11, MSG_COMMAND, 48'd0, 8'd0, 8'd7));
    send_word(mk_item(FUNC_FRAME, 32'd6, 8'hFF, MSG_OTHER, 48'd0, 8'd1, 8'd1));
    send_word(mk_item(FUNC_FRAME, 32'd7, 8'hFF, MSG_OTHER_ALT, 48'd0, 8'd1, 8'd1));
    // forced re-pair, then a timed request far out
    send_word(mk_item(FUNC_REPAIR, 32'd8, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));

    // directed: zero intervals and lengths, one attempt, all-ones address
    program_link(mk_cfg(32'd0, 32'd0, 32'd0, 8'd1, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_START, 32'd0, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd0, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_TICK, 32'd0, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));
    send_word(mk_item(FUNC_FRAME, 32'd1, 8'd0, MSG_PAIR_REPLY, 48'hFFFF_FFFF_FFFF, 8'd0,
                      8'd0));
    send_word(mk_item(FUNC_TICK, 32'd1, 8'd0, MSG_OTHER, 48'd0, 8'd0, 8'd0));

    // random traffic over several register settings and stall patterns
    run_phase(mk_cfg(32'd50, 32'd80, 32'd130, 8'd6, rand_addr(), 8'd11, 8'd12, 8'd12),
              180, 100, 19, 57, 1'b0);
    run_phase(mk_cfg(TimeW'($urandom_range(120, 1)), TimeW'($urandom_range(150)),
                     TimeW'($urandom_range(150)), 8'($urandom_range(10, 1)), rand_addr(),
                     8'($urandom_range(20)), 8'($urandom_range(20)), 8'($urandom_range(20))),
              180, 60, 19, 57, 1'b0);
    run_phase(mk_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 48'd0, 8'hFF, 8'hFF,
                     8'hFF), 180, 0, 57, 19, 1'b0);
    run_phase(mk_cfg(PairIntervalRst, BeatIntervalRst, ReportIntervalRst, MaxAttemptsRst,
                     rand_addr(), MinFrameLenRst, MinPairLenRst, MinCmdLenRst),
              180, 40000, 57, 19, 1'b0);
    run_phase(mk_cfg(32'd0, 32'd0, 32'd0, 8'hFF, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 8'd0),
              180, 3, 0, 0, 1'b1);
    run_phase(mk_cfg(TimeW'($urandom_range(120, 1)), TimeW'($urandom_range(150)),
                     TimeW'($urandom_range(150)), 8'($urandom_range(10, 1)), rand_addr(),
                     8'($urandom_range(20)), 8'($urandom_range(20)), 8'($urandom_range(20))),
              180, 60, 0, 0, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    $display("run covered %0d input words, %0d result words checked, %0d register settings",
             words_sent, words_checked, settings_used);
    $display("including a %0d-cycle result hold-off with the input kept busy", SqueezeCycles);
    if (err_cnt == 0)
      $display("radio_node_pairing_engine regression: pass");
    else
      $display("radio_node_pairing_engine regression: fail");
    $finish;
  end

endmodule
